// ===== rtl/eapt_pkg.sv =====
// shared types, codes and helpers of the emergency alert peer tracker
package eapt_pkg;

  // peer table size and derived widths
  localparam int MAX_PEERS = 16;
  localparam int IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

  // field widths
  localparam int ID_W     = 32;
  localparam int TICK_W   = 20;
  localparam int MODE_W   = 3;
  localparam int KIND_W   = 3;
  localparam int CFG_IDX_W = 8;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 104;

  // event codes carried in the input tuser
  localparam logic [MODE_W-1:0] MODE_START       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STOP        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RAISE       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CANCEL      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PEER_ALERT  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PEER_CANCEL = 3'd5;
  localparam logic [MODE_W-1:0] MODE_TICK        = 3'd6;

  // outgoing message kinds
  localparam logic [KIND_W-1:0] KIND_NONE       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ALERT      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ALERT_ACK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CANCEL     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CANCEL_ACK = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_USER_ID   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_GROUP_ID  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_TIMEOUT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESEND_PERIOD = 8'd3;

  // register reset values
  localparam logic [TICK_W-1:0] PEER_TIMEOUT_RST  = 20'd30000;
  localparam logic [TICK_W-1:0] RESEND_PERIOD_RST = 20'd5000;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan_step;
    logic apply;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic needs_scan;
    logic last_idx;
    logic out_free;
  } dp_status_t;

  // a zero period or timeout loads as one
  function automatic logic [TICK_W-1:0] tick_load(input logic [TICK_W-1:0] v);
    tick_load = (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

// ===== rtl/eapt_ctrl.sv =====
// sequencer that steps the datapath through accept, table sweep and update
module eapt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  eapt_pkg::dp_status_t st,
  output eapt_pkg::dp_cmd_t    cmd
);

  eapt_pkg::ctrl_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      eapt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = st.needs_scan ? eapt_pkg::ST_SCAN : eapt_pkg::ST_APPLY;
        end
      end
      eapt_pkg::ST_SCAN: begin
        if (st.last_idx) begin
          state_nxt = eapt_pkg::ST_APPLY;
        end
      end
      eapt_pkg::ST_APPLY: begin
        if (st.out_free) begin
          state_nxt = eapt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = eapt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready     = 1'b0;
    cmd.load      = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.apply     = 1'b0;
    unique case (state_r)
      eapt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      eapt_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      eapt_pkg::ST_APPLY: begin
        cmd.apply = st.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eapt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/eapt_dp.sv =====
// datapath: config registers, own alert state, peer table and result register
module eapt_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  eapt_pkg::dp_cmd_t                     cmd,
  output eapt_pkg::dp_status_t                  st,
  input  logic [eapt_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic [eapt_pkg::MODE_W-1:0]           in_tuser,
  input  logic                                  cfg_valid,
  input  logic [eapt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [eapt_pkg::ID_W-1:0]             cfg_data,
  input  logic                                  out_tready,
  output logic                                  out_tvalid,
  output logic [eapt_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [eapt_pkg::KIND_W-1:0]           out_tuser
);

  localparam int IW = eapt_pkg::IDX_W;
  localparam int NP = eapt_pkg::MAX_PEERS;
  localparam int TW = eapt_pkg::TICK_W;
  localparam int DW = eapt_pkg::ID_W;

  // configuration registers
  logic [DW-1:0] own_user_r, own_group_r;
  logic [TW-1:0] timeout_r, period_r;

  // captured event
  logic [eapt_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [DW-1:0] pid_r, pid_nxt, porig_r, porig_nxt, pgrp_r, pgrp_nxt;

  // sweep state
  logic [IW-1:0] idx_r, idx_nxt, found_idx_r, found_idx_nxt, free_idx_r, free_idx_nxt;
  logic          found_r, found_nxt, free_r, free_nxt;

  // own alert state
  logic          running_r, running_nxt, emerg_r, emerg_nxt, ract_r, ract_nxt;
  logic [TW-1:0] rcnt_r, rcnt_nxt;

  // peer table
  logic [NP-1:0] valid_r, valid_nxt;
  logic [DW-1:0] ident_r [NP];
  logic [TW-1:0] cdown_r [NP];

  // table write port
  logic          wr_cd_en, wr_id_en;
  logic [IW-1:0] wr_idx;
  logic [TW-1:0] wr_cd;

  // result register
  logic                        ov_r, ov_nxt;
  logic [eapt_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [DW-1:0]               grp_r, grp_nxt, snd_r, snd_nxt, org_r, org_nxt;
  logic                        inem_r, inem_nxt, oth_r, oth_nxt;
  logic                        chg_r, chg_nxt, full_r, full_nxt;

  // entry under the sweep
  logic          cur_valid;
  logic [DW-1:0] cur_ident;
  logic [TW-1:0] cur_cdown;

  assign cur_valid = valid_r[idx_r];
  assign cur_ident = ident_r[idx_r];
  assign cur_cdown = cdown_r[idx_r];

  // status to the sequencer
  assign st.needs_scan = running_r && ((in_tuser == eapt_pkg::MODE_PEER_ALERT) ||
                         (in_tuser == eapt_pkg::MODE_PEER_CANCEL) ||
                         (in_tuser == eapt_pkg::MODE_TICK));
  assign st.last_idx   = (idx_r == IW'(NP - 1));
  assign st.out_free   = !ov_r || out_tready;

  // event handling
  always_comb begin
    mode_nxt      = mode_r;
    pid_nxt       = pid_r;
    porig_nxt     = porig_r;
    pgrp_nxt      = pgrp_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    running_nxt   = running_r;
    emerg_nxt     = emerg_r;
    ract_nxt      = ract_r;
    rcnt_nxt      = rcnt_r;
    valid_nxt     = valid_r;
    wr_cd_en      = 1'b0;
    wr_id_en      = 1'b0;
    wr_idx        = idx_r;
    wr_cd         = '0;
    ov_nxt        = ov_r && !out_tready;
    kind_nxt      = kind_r;
    grp_nxt       = grp_r;
    snd_nxt       = snd_r;
    org_nxt       = org_r;
    inem_nxt      = inem_r;
    oth_nxt       = oth_r;
    chg_nxt       = chg_r;
    full_nxt      = full_r;

    // capture the event and restart the sweep
    if (cmd.load) begin
      mode_nxt  = in_tuser;
      pid_nxt   = in_tdata[31:0];
      porig_nxt = in_tdata[63:32];
      pgrp_nxt  = in_tdata[95:64];
      idx_nxt   = '0;
      found_nxt = 1'b0;
      free_nxt  = 1'b0;
    end

    // one table entry per cycle: lookup, free slot search, timeout countdown
    if (cmd.scan_step) begin
      idx_nxt = idx_r + IW'(1);
      if (cur_valid && (cur_ident == pid_r) && !found_r) begin
        found_nxt     = 1'b1;
        found_idx_nxt = idx_r;
      end
      if (!cur_valid && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = idx_r;
      end
      if ((mode_r == eapt_pkg::MODE_TICK) && cur_valid) begin
        if (cur_cdown <= TW'(1)) begin
          valid_nxt[idx_r] = 1'b0;
        end else begin
          wr_cd_en = 1'b1;
          wr_cd    = cur_cdown - TW'(1);
        end
      end
    end

    // state update and result
    if (cmd.apply) begin
      kind_nxt = eapt_pkg::KIND_NONE;
      grp_nxt  = '0;
      snd_nxt  = '0;
      org_nxt  = '0;
      chg_nxt  = 1'b0;
      full_nxt = 1'b0;
      if (mode_r == eapt_pkg::MODE_START) begin
        if (!running_r) begin
          emerg_nxt   = 1'b0;
          running_nxt = 1'b1;
        end
      end else if (mode_r == eapt_pkg::MODE_STOP) begin
        running_nxt = 1'b0;
        emerg_nxt   = 1'b0;
        rcnt_nxt    = '0;
        ract_nxt    = 1'b0;
        valid_nxt   = '0;
      end else if (running_r) begin
        unique case (mode_r)
          eapt_pkg::MODE_RAISE: begin
            if (!emerg_r) begin
              emerg_nxt = 1'b1;
              rcnt_nxt  = eapt_pkg::tick_load(period_r);
              ract_nxt  = 1'b1;
              kind_nxt  = eapt_pkg::KIND_ALERT;
              grp_nxt   = own_group_r;
              snd_nxt   = own_user_r;
              org_nxt   = own_user_r;
              chg_nxt   = 1'b1;
            end
          end
          eapt_pkg::MODE_CANCEL: begin
            if (emerg_r) begin
              emerg_nxt = 1'b0;
              ract_nxt  = 1'b0;
              rcnt_nxt  = '0;
              kind_nxt  = eapt_pkg::KIND_CANCEL;
              grp_nxt   = own_group_r;
              snd_nxt   = own_user_r;
              org_nxt   = own_user_r;
              chg_nxt   = 1'b1;
            end
          end
          eapt_pkg::MODE_PEER_ALERT: begin
            if (found_r) begin
              wr_cd_en = 1'b1;
              wr_idx   = found_idx_r;
              wr_cd    = eapt_pkg::tick_load(timeout_r);
            end else if (free_r) begin
              valid_nxt[free_idx_r] = 1'b1;
              wr_cd_en = 1'b1;
              wr_id_en = 1'b1;
              wr_idx   = free_idx_r;
              wr_cd    = eapt_pkg::tick_load(timeout_r);
              kind_nxt = eapt_pkg::KIND_ALERT_ACK;
              grp_nxt  = pgrp_r;
              snd_nxt  = own_user_r;
              org_nxt  = pid_r;
            end else begin
              full_nxt = 1'b1;
            end
          end
          eapt_pkg::MODE_PEER_CANCEL: begin
            if (found_r) begin
              valid_nxt[found_idx_r] = 1'b0;
              kind_nxt = eapt_pkg::KIND_CANCEL_ACK;
              grp_nxt  = pgrp_r;
              snd_nxt  = own_user_r;
              org_nxt  = porig_r;
            end
          end
          eapt_pkg::MODE_TICK: begin
            if (ract_r) begin
              if (rcnt_r <= TW'(1)) begin
                if (emerg_r) begin
                  rcnt_nxt = eapt_pkg::tick_load(period_r);
                  kind_nxt = eapt_pkg::KIND_ALERT;
                  grp_nxt  = own_group_r;
                  snd_nxt  = own_user_r;
                  org_nxt  = own_user_r;
                end else begin
                  rcnt_nxt = '0;
                  ract_nxt = 1'b0;
                end
              end else begin
                rcnt_nxt = rcnt_r - TW'(1);
              end
            end
          end
          default: begin
            kind_nxt = eapt_pkg::KIND_NONE;
          end
        endcase
      end
      ov_nxt   = 1'b1;
      inem_nxt = running_nxt && emerg_nxt;
      oth_nxt  = |valid_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      emerg_r   <= 1'b0;
      ract_r    <= 1'b0;
      rcnt_r    <= '0;
      valid_r   <= '0;
      ov_r      <= 1'b0;
      idx_r     <= '0;
      found_r   <= 1'b0;
      free_r    <= 1'b0;
    end else begin
      running_r <= running_nxt;
      emerg_r   <= emerg_nxt;
      ract_r    <= ract_nxt;
      rcnt_r    <= rcnt_nxt;
      valid_r   <= valid_nxt;
      ov_r      <= ov_nxt;
      idx_r     <= idx_nxt;
      found_r   <= found_nxt;
      free_r    <= free_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_user_r  <= '0;
      own_group_r <= '0;
      timeout_r   <= eapt_pkg::PEER_TIMEOUT_RST;
      period_r    <= eapt_pkg::RESEND_PERIOD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        eapt_pkg::CFG_OWN_USER_ID:   own_user_r  <= cfg_data;
        eapt_pkg::CFG_OWN_GROUP_ID:  own_group_r <= cfg_data;
        eapt_pkg::CFG_PEER_TIMEOUT:  timeout_r   <= cfg_data[TW-1:0];
        eapt_pkg::CFG_RESEND_PERIOD: period_r    <= cfg_data[TW-1:0];
        default: begin
          own_user_r <= own_user_r;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    pid_r       <= pid_nxt;
    porig_r     <= porig_nxt;
    pgrp_r      <= pgrp_nxt;
    found_idx_r <= found_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    kind_r      <= kind_nxt;
    grp_r       <= grp_nxt;
    snd_r       <= snd_nxt;
    org_r       <= org_nxt;
    inem_r      <= inem_nxt;
    oth_r       <= oth_nxt;
    chg_r       <= chg_nxt;
    full_r      <= full_nxt;
    if (wr_cd_en) begin
      cdown_r[wr_idx] <= wr_cd;
    end
    if (wr_id_en) begin
      ident_r[wr_idx] <= pid_r;
    end
  end

  // result word
  assign out_tvalid = ov_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {4'd0, full_r, chg_r, oth_r, inem_r, org_r, snd_r, grp_r};

endmodule

// ===== rtl/emergency_alert_peer_tracker.sv =====
// top level of the group-call emergency alert tracker with its peer table
// One input word is one event and gives exactly one result word. Start, stop,
// raise, cancel, unused modes and any event while stopped go straight from
// acceptance to the result register; peer alert, peer cancel and tick while
// running first pass through the sweep that visits one peer table entry per
// cycle for lookup, free slot search and timeout countdown. A new word is taken
// once the previous event has been written to the result register, even while
// that result still waits on out_tready; the block stalls only when a second
// result would overwrite one not yet taken. Configuration writes are taken in
// any cycle (cfg_ready stays high) and must only be issued while idle.
module emergency_alert_peer_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  // input word
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // peer_id [31:0], peer_orig_id [63:32], peer_group_id [95:64]
  input  logic [eapt_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode [2:0]
  input  logic [eapt_pkg::MODE_W-1:0]         in_tuser,
  // result word
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // send_group_id [31:0], send_sender_id [63:32], send_origin_id [95:64],
  // in_emergency [96], others_in_emergency [97], state_changed [98],
  // table_full [99], zero [103:100]
  output logic [eapt_pkg::OUT_DATA_W-1:0]     out_tdata,
  // send_kind [2:0]
  output logic [eapt_pkg::KIND_W-1:0]         out_tuser,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [eapt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eapt_pkg::ID_W-1:0]           cfg_data
);

  eapt_pkg::dp_cmd_t    cmd;
  eapt_pkg::dp_status_t st;

  // registers always take a write
  assign cfg_ready = 1'b1;

  // sequencer
  eapt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath
  eapt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // an accepted word blocks the input until its result is written
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after an accepted word");

  // a result is only written when the result register is free
  a_apply_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> (!out_tvalid || out_tready))
    else $error("result written over a pending result");

  // the table sweep never runs while the input is open
  a_scan_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !in_tready && !cmd.load)
    else $error("table sweep while idle");

endmodule

// ===== verif/eapt_alert_checker.sv =====
// result checker with its own event predictor for the emergency alert peer tracker
module eapt_alert_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // peer_id [31:0], peer_orig_id [63:32], peer_group_id [95:64]
  input  logic [eapt_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode [2:0]
  input  logic [eapt_pkg::MODE_W-1:0]     in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // send_group_id [31:0], send_sender_id [63:32], send_origin_id [95:64],
  // in_emergency [96], others_in_emergency [97], state_changed [98], table_full [99]
  input  logic [eapt_pkg::OUT_DATA_W-1:0] out_tdata,
  // send_kind [2:0]
  input  logic [eapt_pkg::KIND_W-1:0]     out_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [eapt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eapt_pkg::ID_W-1:0]       cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import eapt_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // one outgoing message with its status flags
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   group_id;
    logic [ID_W-1:0]   sender_id;
    logic [ID_W-1:0]   origin_id;
    logic              in_emergency;
    logic              others_in_emergency;
    logic              state_changed;
    logic              table_full;
  } alert_msg_t;

  // register copies
  logic [ID_W-1:0]   own_user_id;
  logic [ID_W-1:0]   own_group_id;
  logic [TICK_W-1:0] peer_timeout;
  logic [TICK_W-1:0] resend_period;

  // predicted tracker state
  logic                 running;
  logic                 emergency;
  logic                 resend_active;
  logic [TICK_W-1:0]    resend_count;
  logic [MAX_PEERS-1:0] peer_valid;
  logic [ID_W-1:0]      peer_ident [MAX_PEERS];
  logic [TICK_W-1:0]    peer_countdown [MAX_PEERS];

  alert_msg_t expected_msgs[$];
  alert_msg_t got_msg;
  alert_msg_t want_msg;
  int         err_count = 0;

  assign fail_count = err_count;

  // a zero register still gives one tick
  function automatic logic [TICK_W-1:0] reload_ticks(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  // message carrying the own ids, used by alerts and cancels
  function automatic alert_msg_t own_msg(input logic [KIND_W-1:0] kind);
    alert_msg_t m;
    m = '0;
    m.kind      = kind;
    m.group_id  = own_group_id;
    m.sender_id = own_user_id;
    m.origin_id = own_user_id;
    return m;
  endfunction

  // apply one event to the predicted state and give its result
  function automatic alert_msg_t track_event(input logic [MODE_W-1:0] mode,
                                             input logic [ID_W-1:0] pid,
                                             input logic [ID_W-1:0] porig,
                                             input logic [ID_W-1:0] pgrp);
    alert_msg_t r;
    int         hit;
    int         slot;
    int         i;
    r    = '0;
    hit  = -1;
    slot = -1;
    if (mode == MODE_START) begin
      if (!running) begin
        emergency = 1'b0;
        running   = 1'b1;
      end
    end else if (mode == MODE_STOP) begin
      running       = 1'b0;
      emergency     = 1'b0;
      resend_active = 1'b0;
      resend_count  = '0;
      peer_valid    = '0;
    end else if (running) begin
      case (mode)
        MODE_RAISE: begin
          if (!emergency) begin
            emergency     = 1'b1;
            resend_count  = reload_ticks(resend_period);
            resend_active = 1'b1;
            r = own_msg(KIND_ALERT);
            r.state_changed = 1'b1;
          end
        end
        MODE_CANCEL: begin
          if (emergency) begin
            emergency     = 1'b0;
            resend_active = 1'b0;
            resend_count  = '0;
            r = own_msg(KIND_CANCEL);
            r.state_changed = 1'b1;
          end
        end
        MODE_PEER_ALERT: begin
          // lowest matching entry wins, new peers take the lowest free entry
          for (i = MAX_PEERS - 1; i >= 0; i--) begin
            if (peer_valid[i] && peer_ident[i] == pid) hit = i;
            if (!peer_valid[i]) slot = i;
          end
          if (hit >= 0) begin
            peer_countdown[hit] = reload_ticks(peer_timeout);
          end else if (slot >= 0) begin
            peer_valid[slot]     = 1'b1;
            peer_ident[slot]     = pid;
            peer_countdown[slot] = reload_ticks(peer_timeout);
            r.kind      = KIND_ALERT_ACK;
            r.group_id  = pgrp;
            r.sender_id = own_user_id;
            r.origin_id = pid;
          end else begin
            r.table_full = 1'b1;
          end
        end
        MODE_PEER_CANCEL: begin
          for (i = MAX_PEERS - 1; i >= 0; i--)
            if (peer_valid[i] && peer_ident[i] == pid) hit = i;
          if (hit >= 0) begin
            peer_valid[hit] = 1'b0;
            r.kind      = KIND_CANCEL_ACK;
            r.group_id  = pgrp;
            r.sender_id = own_user_id;
            r.origin_id = porig;
          end
        end
        MODE_TICK: begin
          // peers age first, then the resend countdown
          for (i = 0; i < MAX_PEERS; i++) begin
            if (peer_valid[i]) begin
              if (peer_countdown[i] <= 1) begin
                peer_countdown[i] = '0;
                peer_valid[i]     = 1'b0;
              end else begin
                peer_countdown[i] = peer_countdown[i] - 1'b1;
              end
            end
          end
          if (resend_active) begin
            if (resend_count <= 1) begin
              if (emergency) begin
                resend_count = reload_ticks(resend_period);
                r = own_msg(KIND_ALERT);
              end else begin
                resend_count  = '0;
                resend_active = 1'b0;
              end
            end else begin
              resend_count = resend_count - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    r.in_emergency        = running && emergency;
    r.others_in_emergency = |peer_valid;
    return r;
  endfunction

  function automatic string show_msg(input alert_msg_t m);
    return $sformatf("kind=%0d grp=%h snd=%h org=%h emerg=%b others=%b changed=%b full=%b",
                     m.kind, m.group_id, m.sender_id, m.origin_id, m.in_emergency,
                     m.others_in_emergency, m.state_changed, m.table_full);
  endfunction

  // watch all three channels
  always @(posedge clk) begin
    if (!rst_n) begin
      own_user_id   <= '0;
      own_group_id  <= '0;
      peer_timeout  <= PEER_TIMEOUT_RST;
      resend_period <= RESEND_PERIOD_RST;
      running       = 1'b0;
      emergency     = 1'b0;
      resend_active = 1'b0;
      resend_count  = '0;
      peer_valid    = '0;
      expected_msgs.delete();
      pending <= 0;
    end else begin
      // compare a taken result word with the oldest prediction
      if (out_tvalid && out_tready) begin
        got_msg.kind                = out_tuser;
        got_msg.group_id            = out_tdata[31:0];
        got_msg.sender_id           = out_tdata[63:32];
        got_msg.origin_id           = out_tdata[95:64];
        got_msg.in_emergency        = out_tdata[96];
        got_msg.others_in_emergency = out_tdata[97];
        got_msg.state_changed       = out_tdata[98];
        got_msg.table_full          = out_tdata[99];
        if (expected_msgs.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("[%0t] result word with none pending: %s", $realtime, show_msg(got_msg));
        end else begin
          want_msg = expected_msgs.pop_front();
          if (got_msg.kind !== want_msg.kind || got_msg.group_id !== want_msg.group_id ||
              got_msg.sender_id !== want_msg.sender_id ||
              got_msg.origin_id !== want_msg.origin_id ||
              got_msg.in_emergency !== want_msg.in_emergency ||
              got_msg.others_in_emergency !== want_msg.others_in_emergency ||
              got_msg.state_changed !== want_msg.state_changed ||
              got_msg.table_full !== want_msg.table_full) begin
            err_count++;
            if (err_count <= REPORT_LIMIT) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected %s", show_msg(want_msg));
              $display("  actual   %s", show_msg(got_msg));
            end
          end
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OWN_USER_ID:   own_user_id   <= cfg_data;
          CFG_OWN_GROUP_ID:  own_group_id  <= cfg_data;
          CFG_PEER_TIMEOUT:  peer_timeout  <= cfg_data[TICK_W-1:0];
          CFG_RESEND_PERIOD: resend_period <= cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      // predict the result of an accepted event word and queue it at the tail
      if (in_tvalid && in_tready)
        expected_msgs = {expected_msgs, track_event(in_tuser, in_tdata[31:0],
                                                    in_tdata[63:32], in_tdata[95:64])};
      pending <= expected_msgs.size();
    end
  end

endmodule

// ===== verif/tb_emergency_alert_peer_tracker.sv =====
// stimulus, clock, reset and verdict for the emergency alert peer tracker
module tb_emergency_alert_peer_tracker;
  import eapt_pkg::*;

  localparam int RANDOM_EVENTS = 1950;
  localparam int NUM_PHASES    = 6;
  localparam int POOL_SIZE     = 24;
  localparam int IDLE_LIMIT    = 4000;
  // well past the longest sweep of the block
  localparam int DRAIN_CYCLES  = 40;
  localparam logic [MODE_W-1:0]    MODE_UNUSED      = 3'd7;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_INDEX = 8'hFF;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ID_W-1:0]       cfg_data;

  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          stall_left = 0;
  int          counted = 0;
  bit          quiet = 1'b0;
  bit          running_guess = 1'b0;
  logic [31:0] id_pool [POOL_SIZE];

  always #2 clk = ~clk;

  emergency_alert_peer_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  eapt_alert_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_tready = 1'b0;
      stall_left = $urandom_range(1, 17) - 1;
    end else begin
      out_tready = 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ids lean toward the extremes now and then
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // send one event word, then maybe leave a gap
  task automatic push_event(input logic [MODE_W-1:0] mode, input logic [31:0] pid,
                            input logic [31:0] porig, input logic [31:0] pgrp);
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = {pgrp, porig, pid};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
    if (!quiet && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 17)) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold the sender until every result is back and the block is idle
  task automatic settle_idle();
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // random event with random echoed ids; events other than start and stop sent while stopped are not counted
  task automatic send_counted(input logic [MODE_W-1:0] mode, input logic [31:0] pid);
    if (running_guess || mode == MODE_START || mode == MODE_STOP) counted++;
    if (mode == MODE_START) running_guess = 1'b1;
    if (mode == MODE_STOP) running_guess = 1'b0;
    push_event(mode, pid, rand_word(), rand_word());
  endtask

  initial begin
    int                phase;
    int                target;
    int                pick;
    int                k;
    logic [MODE_W-1:0] mode;
    logic [31:0]       pid;
    logic [31:0]       user_id;
    logic [31:0]       group_id;
    logic [31:0]       timeout_word;
    logic [31:0]       period_word;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = MODE_START;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_OWN_USER_ID;
    cfg_data   = '0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: short countdowns so resend and peer expiry show up quickly
    write_reg(CFG_OWN_USER_ID, 32'hFFFF_FFFF);
    write_reg(CFG_OWN_GROUP_ID, 32'h0000_0000);
    write_reg(CFG_PEER_TIMEOUT, 32'd2);
    write_reg(CFG_RESEND_PERIOD, 32'd2);
    push_event(MODE_TICK, 32'h0, 32'h0, 32'h0);
    push_event(MODE_PEER_ALERT, 32'h1234_5678, 32'h0, 32'h1);
    push_event(MODE_STOP, 32'h0, 32'h0, 32'h0);
    push_event(MODE_START, 32'h0, 32'h0, 32'h0);
    push_event(MODE_START, 32'h0, 32'h0, 32'h0);
    push_event(MODE_RAISE, 32'h0, 32'h0, 32'h0);
    push_event(MODE_RAISE, 32'h0, 32'h0, 32'h0);
    push_event(MODE_TICK, 32'h0, 32'h0, 32'h0);
    push_event(MODE_TICK, 32'h0, 32'h0, 32'h0);
    push_event(MODE_PEER_ALERT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    push_event(MODE_PEER_ALERT, 32'h0, 32'hFFFF_FFFF, 32'h0);
    push_event(MODE_PEER_ALERT, 32'hFFFF_FFFF, 32'h0, 32'h5A5A_5A5A);
    push_event(MODE_PEER_CANCEL, 32'h0, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    push_event(MODE_PEER_CANCEL, 32'h0000_0005, 32'h1, 32'h2);
    push_event(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_event(MODE_CANCEL, 32'h0, 32'h0, 32'h0);
    push_event(MODE_CANCEL, 32'h0, 32'h0, 32'h0);
    push_event(MODE_TICK, 32'h0, 32'h0, 32'h0);
    push_event(MODE_TICK, 32'h0, 32'h0, 32'h0);
    push_event(MODE_RAISE, 32'h0, 32'h0, 32'h0);
    push_event(MODE_START, 32'h0, 32'h0, 32'h0);
    push_event(MODE_PEER_ALERT, 32'h0000_0007, 32'h0, 32'h3);
    push_event(MODE_STOP, 32'h0, 32'h0, 32'h0);
    push_event(MODE_START, 32'h0, 32'h0, 32'h0);
    push_event(MODE_TICK, 32'h0, 32'h0, 32'h0);
    running_guess = 1'b1;

    // random phases, each under its own register setting
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle_idle();
      quiet = (phase == NUM_PHASES - 1);
      case (phase)
        0: begin
          user_id      = 32'h0000_0000;
          group_id     = 32'hFFFF_FFFF;
          timeout_word = 32'h0;
          period_word  = 32'h0;
        end
        1: begin
          user_id      = 32'hFFFF_FFFF;
          group_id     = 32'h0000_0000;
          timeout_word = 32'hFFFF_FFFF;
          period_word  = 32'hFFFF_FFFF;
        end
        default: begin
          user_id      = rand_word();
          group_id     = rand_word();
          timeout_word = ($urandom() & 32'hFFF0_0000) | $urandom_range(1, 60);
          period_word  = ($urandom() & 32'hFFF0_0000) | $urandom_range(1, 30);
        end
      endcase
      write_reg(CFG_OWN_USER_ID, user_id);
      write_reg(CFG_OWN_GROUP_ID, group_id);
      write_reg(CFG_PEER_TIMEOUT, timeout_word);
      write_reg(CFG_RESEND_PERIOD, period_word);
      if (phase == 2) write_reg(UNUSED_REG_INDEX, $urandom());
      for (k = 0; k < POOL_SIZE; k++) id_pool[k] = rand_word();

      target = counted + RANDOM_EVENTS / NUM_PHASES;
      while (counted < target) begin
        if (!quiet && $urandom_range(0, 299) == 0) settle_idle();
        pick = $urandom_range(0, 999);
        pid  = ($urandom_range(0, 4) == 0) ? rand_word() : id_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (!running_guess && pick < 750) begin
          send_counted(MODE_START, pid);
        end else if (pick < 15) begin
          // flood of new peers, enough to overflow the table
          repeat (MAX_PEERS + 2) send_counted(MODE_PEER_ALERT, rand_word());
        end else begin
          if (pick < 35)       mode = MODE_START;
          else if (pick < 47)  mode = MODE_STOP;
          else if (pick < 127) mode = MODE_RAISE;
          else if (pick < 187) mode = MODE_CANCEL;
          else if (pick < 517) mode = MODE_PEER_ALERT;
          else if (pick < 667) mode = MODE_PEER_CANCEL;
          else if (pick < 987) mode = MODE_TICK;
          else                 mode = MODE_UNUSED;
          send_counted(mode, pid);
        end
      end
    end

    // wait for the tail of the run, then give the verdict
    settle_idle();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
